>>> rtl/lrs_pkg.sv
// Shared types and constants for the linear resampler
package lrs_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int MAX_RESULTS   = 64;
    localparam int VAL_W         = 34;
    localparam int RATE_W        = 19;
    localparam int CNT_W         = 32;
    localparam int FMT_W         = 2;
    localparam int PCM_W         = 16;
    localparam int DIV_W         = 52;
    localparam int SHORT_BITS    = RATE_W + FRACTION_BITS;
    localparam int DCNT_W        = $clog2(DIV_W + 1);
    localparam int N_W           = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W     = 2;

    localparam logic [RATE_W-1:0] RESET_RATE = RATE_W'(44100);

    typedef enum logic [FMT_W-1:0] {
        FMT_INT16   = 2'd0,
        FMT_INT24   = 2'd1,
        FMT_INT32   = 2'd2,
        FMT_FLOAT32 = 2'd3
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_FORMAT = 2'd0,
        CFG_SOURCE_RATE   = 2'd1,
        CFG_TARGET_RATE   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] raw_sample;
        logic        final_input;
    } in_item_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_out;
        logic                    sample_valid;
        logic                    stream_end;
    } out_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } q_item_t;

    typedef struct packed {
        logic              start;
        logic              short_op;
        logic [DIV_W-1:0]  dividend;
        logic [RATE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [RATE_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KT,
        ST_MUL,
        ST_CMP,
        ST_DIVP,
        ST_DIVQ,
        ST_INTERP,
        ST_CLAMP,
        ST_SCALE,
        ST_EMIT,
        ST_DIVS,
        ST_FINISH
    } back_state_t;

endpackage

>>> rtl/lrs_front.sv
// Input side: accept samples and normalize them to Q2.31
module lrs_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  lrs_pkg::in_item_t  in_data,
    input  logic [1:0]         source_format,
    input  logic               q_full,
    output logic               push,
    output lrs_pkg::q_item_t   push_data
);
    import lrs_pkg::*;

    function automatic logic signed [VAL_W-1:0] decode_float(input logic [31:0] raw);
        logic [7:0]  expo;
        logic [22:0] mant;
        logic [23:0] full;
        logic [32:0] mag;
        logic [4:0]  sh;
        expo = raw[30:23];
        mant = raw[22:0];
        full = {1'b1, mant};
        mag  = '0;
        sh   = '0;
        if (expo == 8'hFF)
        begin
            // infinity saturates, NaN reads as zero
            mag = (mant != '0) ? 33'd0 : {1'b1, 32'd0};
        end
        else if (expo == 8'd0)
        begin
            mag = '0;
        end
        else if (expo >= 8'd128)
        begin
            mag = {1'b1, 32'd0};
        end
        else if (expo >= 8'd119)
        begin
            sh  = 5'(expo - 8'd119);
            mag = 33'(full) << sh;
        end
        else if (expo >= 8'd95)
        begin
            sh  = 5'(8'd119 - expo);
            mag = 33'(full >> sh);
        end
        else
        begin
            mag = '0;
        end
        return raw[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    logic signed [VAL_W-1:0] norm;

    always_comb
    begin
        case (fmt_t'(source_format))
            FMT_INT16: norm = VAL_W'($signed(in_data.raw_sample[15:0])) <<< 16;
            FMT_INT24: norm = VAL_W'($signed(in_data.raw_sample[23:0])) <<< 8;
            FMT_INT32: norm = VAL_W'($signed(in_data.raw_sample));
            default:   norm = decode_float(in_data.raw_sample);
        endcase
    end

    assign in_stall        = q_full;
    assign push            = in_valid && !q_full;
    assign push_data.value = norm;
    assign push_data.last  = in_data.final_input;

endmodule

>>> rtl/lrs_fifo.sv
// Short queue between the input side and the output sequencer
module lrs_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lrs_pkg::q_item_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output lrs_pkg::q_item_t  pop_data
);
    import lrs_pkg::*;

    q_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_reg;
    logic [QPTR_W-1:0]  wr_next;
    logic [QPTR_W-1:0]  rd_reg;
    logic [QPTR_W-1:0]  rd_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? QPTR_W'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? QPTR_W'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = QCNT_W'(cnt_reg + 1'b1);
        else if (pop && !push)
            cnt_next = QCNT_W'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/lrs_div.sv
// Restoring divider, one quotient bit per cycle
module lrs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  lrs_pkg::div_req_t  req,
    output lrs_pkg::div_rsp_t  rsp
);
    import lrs_pkg::*;

    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dvd_next;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] rem_next;
    logic [RATE_W-1:0] dsr_reg;
    logic [RATE_W-1:0] dsr_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [RATE_W:0]   trial;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        ge        = (trial >= {1'b0, dsr_reg});
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? RATE_W'(trial - {1'b0, dsr_reg}) : RATE_W'(trial);
            cnt_next = DCNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            // left-align the short dividend so the same loop serves both uses
            dvd_next  = req.short_op ? (req.dividend << (DIV_W - SHORT_BITS)) : req.dividend;
            cnt_next  = req.short_op ? DCNT_W'(SHORT_BITS) : DCNT_W'(DIV_W);
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = req.divisor;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> rtl/lrs_back.sv
// Output sequencer: schedules, interpolates and scales the output samples
module lrs_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  lrs_pkg::q_item_t          q_data,
    output logic                      q_pop,
    input  logic [lrs_pkg::RATE_W-1:0] source_rate,
    input  logic [lrs_pkg::RATE_W-1:0] target_rate,
    output lrs_pkg::div_req_t         div_req,
    input  lrs_pkg::div_rsp_t         div_rsp,
    output logic                      out_valid,
    input  logic                      out_stall,
    output lrs_pkg::out_item_t        out_data
);
    import lrs_pkg::*;

    localparam int V_W = VAL_W + FRACTION_BITS + 3;
    localparam int C_W = 33;
    localparam int M_W = C_W + PCM_W - 1;
    localparam logic signed [C_W-1:0] LIM = C_W'(64'sd2147483648);
    localparam logic signed [M_W-1:0] PCM_SCALE = M_W'(32767);

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [VAL_W-1:0]   cur_reg;
    logic                      last_reg;
    logic signed [VAL_W-1:0]   prev_reg;
    logic [CNT_W-1:0]          k_reg;
    // one spare bit: the output index may pass 2^32 within a beat
    logic [CNT_W:0]            i_reg;
    logic [N_W-1:0]            n_reg;
    logic [DIV_W-1:0]          kt_reg;
    logic [DIV_W-1:0]          p_reg;
    logic [DIV_W-1:0]          bound_reg;
    logic signed [VAL_W-1:0]   lft_reg;
    logic signed [VAL_W-1:0]   rgt_reg;
    logic [FRACTION_BITS:0]    q_reg;
    logic                      fin_reg;
    logic signed [V_W-1:0]     v_reg;
    logic signed [C_W-1:0]     c_reg;
    logic signed [M_W-1:0]     m_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic [RATE_W-1:0]         s_eff;
    logic                      due;
    logic                      cap;
    logic                      at_end;
    logic                      next_due;
    logic                      fin;
    logic                      slot_free;
    logic                      load_out;
    logic signed [VAL_W:0]     diff;
    logic signed [V_W-1:0]     v_trunc;
    logic signed [M_W-1:0]     m_trunc;
    out_item_t                 out_load;

    assign s_eff     = (source_rate == '0) ? RATE_W'(1) : source_rate;
    assign due       = (p_reg < bound_reg);
    assign cap       = (n_reg == N_W'(MAX_RESULTS));
    assign at_end    = (p_reg >= kt_reg);
    assign next_due  = ((p_reg + DIV_W'(s_eff)) < bound_reg);
    assign fin       = last_reg && ((n_reg == N_W'(MAX_RESULTS - 1)) || !next_due);
    assign slot_free = !out_valid_reg || !out_stall;
    assign diff      = VAL_W'(0) + ($signed({rgt_reg[VAL_W-1], rgt_reg})
                       - $signed({lft_reg[VAL_W-1], lft_reg}));

    // truncate toward zero on both scaling shifts
    always_comb
    begin
        v_trunc = (v_reg + (v_reg < 0 ? V_W'((1 << FRACTION_BITS) - 1) : V_W'(0)))
                  >>> FRACTION_BITS;
        m_trunc = (m_reg + (m_reg < 0 ? M_W'(64'sd2147483647) : M_W'(0))) >>> 31;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_KT;
            ST_KT:     state_next = ST_MUL;
            ST_MUL:    state_next = ST_CMP;
            ST_CMP:
            begin
                if (!due)
                    state_next = ST_FINISH;
                else if (cap)
                    state_next = ST_DIVS;
                else if (at_end)
                    state_next = ST_INTERP;
                else
                    state_next = ST_DIVP;
            end
            ST_DIVP:   if (div_rsp.done) state_next = ST_DIVQ;
            ST_DIVQ:   if (div_rsp.done) state_next = ST_INTERP;
            ST_INTERP: state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_EMIT;
            ST_EMIT:   if (slot_free) state_next = fin_reg ? ST_FINISH : ST_MUL;
            ST_DIVS:   if (div_rsp.done) state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!(last_reg && n_reg == '0) || slot_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop                = 1'b0;
        div_req.start        = 1'b0;
        div_req.short_op     = 1'b0;
        div_req.dividend     = p_reg;
        div_req.divisor      = target_rate;
        load_out             = 1'b0;
        out_load.pcm_out     = PCM_W'(m_trunc);
        out_load.sample_valid = 1'b1;
        out_load.stream_end  = fin_reg;
        case (state_reg)
            ST_IDLE: q_pop = q_valid;
            ST_CMP:
            begin
                if (due && cap)
                begin
                    // skip the due outputs beyond the cap: i = ceil(bound / s)
                    div_req.start    = 1'b1;
                    div_req.dividend = bound_reg + DIV_W'(s_eff) - DIV_W'(1);
                    div_req.divisor  = s_eff;
                end
                else if (due && !at_end)
                begin
                    div_req.start = 1'b1;
                end
            end
            ST_DIVP:
            begin
                div_req.start    = div_rsp.done;
                div_req.short_op = 1'b1;
                div_req.dividend = DIV_W'(div_rsp.remainder) << FRACTION_BITS;
            end
            ST_EMIT: load_out = slot_free;
            ST_FINISH:
            begin
                if (last_reg && n_reg == '0)
                begin
                    load_out              = slot_free;
                    out_load.pcm_out      = '0;
                    out_load.sample_valid = 1'b0;
                    out_load.stream_end   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg  <= q_data.value;
                last_reg <= q_data.last;
            end
            ST_KT:   kt_reg <= DIV_W'(k_reg) * DIV_W'(target_rate);
            ST_MUL:
            begin
                p_reg     <= DIV_W'(i_reg) * DIV_W'(s_eff);
                bound_reg <= last_reg ? kt_reg + DIV_W'(target_rate) : kt_reg;
            end
            ST_CMP:
            begin
                fin_reg <= fin;
                lft_reg <= cur_reg;
                rgt_reg <= cur_reg;
                q_reg   <= '0;
            end
            ST_DIVQ:
            begin
                lft_reg <= prev_reg;
                q_reg   <= {1'b0, div_rsp.quotient[FRACTION_BITS-1:0]};
            end
            ST_INTERP:
            begin
                v_reg <= (V_W'(lft_reg) <<< FRACTION_BITS)
                         + V_W'(diff) * V_W'($signed({1'b0, q_reg}));
            end
            ST_CLAMP:
            begin
                if (v_trunc > V_W'(LIM))
                    c_reg <= LIM;
                else if (v_trunc < -V_W'(LIM))
                    c_reg <= -LIM;
                else
                    c_reg <= C_W'(v_trunc);
            end
            ST_SCALE: m_reg <= M_W'(c_reg) * PCM_SCALE;
            default: ;
        endcase
        if (load_out)
            out_data_reg <= out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: n_reg <= '0;
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        n_reg <= N_W'(n_reg + 1'b1);
                        i_reg <= (CNT_W+1)'(i_reg + 1'b1);
                    end
                end
                ST_DIVS: if (div_rsp.done) i_reg <= {1'b0, div_rsp.quotient[CNT_W-1:0]};
                ST_FINISH:
                begin
                    if (state_next == ST_IDLE)
                    begin
                        if (last_reg)
                        begin
                            prev_reg <= '0;
                            k_reg    <= '0;
                            i_reg    <= '0;
                        end
                        else
                        begin
                            prev_reg <= cur_reg;
                            k_reg    <= CNT_W'(k_reg + 1'b1);
                            // the stored count wraps at 32 bits
                            i_reg    <= {1'b0, i_reg[CNT_W-1:0]};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/pcm_format_linear_resampler.sv
// Linear-interpolation resampler for one PCM channel.
// Input channel: in_valid / in_stall carry one raw sample per beat (int16, int24,
// int32 or float32, chosen by source_format) with final_input on the last one.
// Output channel: out_valid / out_stall carry resampled 16-bit samples; the last
// result of a stream has stream_end set, and a stream with no output samples
// ends in one beat with sample_valid low.
// Config: cfg_we, cfg_index, cfg_data write source_format, source_rate and
// target_rate; write them only while the block is idle.
// Flow: the input side normalizes a sample in the accept cycle and parks it in
// a two-entry queue, so inputs keep flowing while the sequencer works. Each
// output sample interpolated between two inputs uses the shared restoring
// divider twice (52 steps for the phase remainder, 35 for the fraction). An
// output sitting on the last input skips the divider, and a capped burst uses
// one division to skip past the due outputs beyond the cap.
// Reset: all stream state clears and the rates return to 44100 Hz, int16.
// Stall: a result holds in the output register; the sequencer waits, and the
// input side keeps taking samples until the queue fills.
module pcm_format_linear_resampler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  lrs_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output lrs_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrs_pkg::RATE_W-1:0]    cfg_data
);
    import lrs_pkg::*;

    logic [FMT_W-1:0]  source_format_reg;
    logic [RATE_W-1:0] source_rate_reg;
    logic [RATE_W-1:0] target_rate_reg;

    logic     q_full;
    logic     push;
    q_item_t  push_data;
    logic     q_valid;
    logic     q_pop;
    q_item_t  q_data;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= FMT_INT16;
            source_rate_reg   <= RESET_RATE;
            target_rate_reg   <= RESET_RATE;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SOURCE_FORMAT: source_format_reg <= cfg_data[FMT_W-1:0];
                CFG_SOURCE_RATE:   source_rate_reg   <= cfg_data;
                CFG_TARGET_RATE:   target_rate_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    lrs_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .source_format (source_format_reg),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    lrs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    lrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .source_rate (source_rate_reg),
        .target_rate (target_rate_reg),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

>>> rtl/lrs_checker.sv
// Port-level checks for the resampler, bound to the top level
module lrs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input lrs_pkg::out_item_t out_data
);
    import lrs_pkg::*;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sample_valid |-> out_data.stream_end)
        else $error("bare marker without stream end");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sample_valid |-> out_data.pcm_out == '0)
        else $error("bare marker carries a sample value");

    a_pcm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sample_valid |-> out_data.pcm_out != PCM_W'(16'h8000))
        else $error("output sample out of range");

endmodule

bind pcm_format_linear_resampler lrs_checker u_lrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
